FILE: hw/rtl/sdf_pkg.sv
// Shared types and constants for the signed decimal formatter.
// Holds character codes, register indexes, length modes and the
// command/status structs between controller and datapath. No dependencies.
package sdf_pkg;

    localparam int MAX_WIDTH_DEF = 32;

    // Twenty BCD digits cover the full unsigned 64-bit magnitude.
    localparam int MAG_W   = 64;
    localparam int ND_MAX  = 20;
    localparam int BCD_W   = 4 * ND_MAX;
    localparam int ND_W    = $clog2(ND_MAX + 1);
    localparam int STEPS   = MAG_W;
    localparam int STEP_W  = $clog2(STEPS);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] REG_FIELD_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_JUSTIFY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_PAD     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FORCE_PLUS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_MODE  = 3'd4;

    localparam logic [2:0] LM_INT    = 3'd0;
    localparam logic [2:0] LM_CHAR   = 3'd1;
    localparam logic [2:0] LM_SHORT  = 3'd2;
    localparam logic [2:0] LM_LONG   = 3'd3;
    localparam logic [2:0] LM_LLONG  = 3'd4;
    localparam logic [2:0] LM_INTMAX = 3'd5;
    localparam logic [2:0] LM_SIZE   = 3'd6;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;

    typedef enum logic [1:0] {
        KIND_SPACE,
        KIND_ZERO,
        KIND_SIGN,
        KIND_DIGIT
    } char_kind_t;

    typedef struct packed {
        logic       load;
        logic       dabble;
        logic       norm;
        logic       emit;
        char_kind_t kind;
        logic       last;
    } sdf_cmd_t;

    typedef struct packed {
        logic top_zero;
        logic has_sign;
        logic out_free;
    } sdf_sts_t;

endpackage

FILE: hw/rtl/sdf_arg_if.sv
// Input channel carrying one raw argument per beat.
// Depends on nothing.
interface sdf_arg_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] raw_value;

    modport source (output valid, output raw_value, input ready);
    modport sink   (input valid, input raw_value, output ready);
endinterface

FILE: hw/rtl/sdf_text_if.sv
// Output channel carrying one text character per beat.
// Depends on nothing.
interface sdf_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_char;

    modport source (output valid, output out_char, output last_char, input ready);
    modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

FILE: hw/rtl/signed_decimal_formatter.sv
// Top level of the signed decimal formatter: configuration registers and
// the controller/datapath pair. Depends on sdf_pkg, sdf_arg_if,
// sdf_text_if, sdf_ctrl and sdf_datapath.
//
//   Port      Dir   Payload                 Role
//   arg       in    raw_value[63:0] signed  one argument per beat
//   text      out   out_char[7:0], last_char one character per beat
//   cfg_*     in    cfg_index[2:0], cfg_data[5:0] register write
//
// One item goes through an accept step, shift-add-3 conversion and
// leading-zero removal, then emits its characters, one per cycle when
// the output side takes every beat.
// The converter handles one item at a time; a new argument is taken as soon
// as the final character sits in the output register.
// Stalls on the output hold the sequence in place. Reset clears the
// configuration registers to zero and the controller to idle.
module signed_decimal_formatter #(
    parameter int MAX_WIDTH = sdf_pkg::MAX_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    sdf_arg_if.sink                           arg,
    sdf_text_if.source                        text,
    input  logic                              cfg_we,
    input  logic [sdf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sdf_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [5:0]         field_width_reg;
    logic               left_justify_reg;
    logic               zero_pad_reg;
    logic               force_plus_reg;
    logic [2:0]         length_mode_reg;
    sdf_pkg::sdf_cmd_t  cmd;
    sdf_pkg::sdf_sts_t  sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_width_reg  <= '0;
            left_justify_reg <= 1'b0;
            zero_pad_reg     <= 1'b0;
            force_plus_reg   <= 1'b0;
            length_mode_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sdf_pkg::REG_FIELD_WIDTH:  field_width_reg  <= cfg_data[5:0];
                sdf_pkg::REG_LEFT_JUSTIFY: left_justify_reg <= cfg_data[0];
                sdf_pkg::REG_ZERO_PAD:     zero_pad_reg     <= cfg_data[0];
                sdf_pkg::REG_FORCE_PLUS:   force_plus_reg   <= cfg_data[0];
                sdf_pkg::REG_LENGTH_MODE:  length_mode_reg  <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    sdf_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (arg.valid),
        .in_ready     (arg.ready),
        .field_width  (field_width_reg),
        .left_justify (left_justify_reg),
        .zero_pad     (zero_pad_reg),
        .sts          (sts),
        .cmd          (cmd)
    );

    sdf_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .raw_value   (arg.raw_value),
        .length_mode (length_mode_reg),
        .force_plus  (force_plus_reg),
        .cmd         (cmd),
        .sts         (sts),
        .out_ready   (text.ready),
        .out_valid   (text.valid),
        .out_char    (text.out_char),
        .last_char   (text.last_char)
    );

endmodule

FILE: hw/rtl/sdf_datapath.sv
// Datapath: narrowing, magnitude, shift-add-3 binary to BCD converter and
// the output character register. Driven by sdf_ctrl through sdf_pkg structs.
module sdf_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [63:0]          raw_value,
    input  logic [2:0]           length_mode,
    input  logic                 force_plus,
    input  sdf_pkg::sdf_cmd_t    cmd,
    output sdf_pkg::sdf_sts_t    sts,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [7:0]           out_char,
    output logic                 last_char
);

    logic [63:0]                   narrowed;
    logic [sdf_pkg::MAG_W-1:0]     mag;
    logic [sdf_pkg::MAG_W-1:0]     mag_reg;
    logic [sdf_pkg::BCD_W-1:0]     bcd_reg;
    logic [sdf_pkg::BCD_W-1:0]     bcd_adj;
    logic [3:0]                    top_digit;
    logic                          neg_reg;
    logic                          out_valid_reg;
    logic [7:0]                    out_char_reg;
    logic                          last_char_reg;
    logic [7:0]                    char_next;

    always_comb
    begin
        case (length_mode)
            sdf_pkg::LM_CHAR:   narrowed = {{56{raw_value[7]}}, raw_value[7:0]};
            sdf_pkg::LM_SHORT:  narrowed = {{48{raw_value[15]}}, raw_value[15:0]};
            sdf_pkg::LM_LONG,
            sdf_pkg::LM_LLONG,
            sdf_pkg::LM_INTMAX,
            sdf_pkg::LM_SIZE:   narrowed = raw_value;
            default:            narrowed = {{32{raw_value[31]}}, raw_value[31:0]};
        endcase
        mag = narrowed[63] ? (64'd0 - narrowed) : narrowed;
    end

    // Every digit of five or more gets three added before the shift.
    always_comb
    begin
        for (int i = 0; i < sdf_pkg::ND_MAX; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    assign top_digit = bcd_reg[sdf_pkg::BCD_W-1 -: 4];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mag_reg <= mag;
            bcd_reg <= '0;
            neg_reg <= narrowed[63];
        end
        else if (cmd.dabble)
        begin
            {bcd_reg, mag_reg} <= {bcd_adj[sdf_pkg::BCD_W-2:0], mag_reg, 1'b0};
        end
        else if (cmd.norm || (cmd.emit && cmd.kind == sdf_pkg::KIND_DIGIT))
        begin
            bcd_reg <= {bcd_reg[sdf_pkg::BCD_W-5:0], 4'd0};
        end
    end

    always_comb
    begin
        case (cmd.kind)
            sdf_pkg::KIND_SPACE: char_next = sdf_pkg::CH_SPACE;
            sdf_pkg::KIND_ZERO:  char_next = sdf_pkg::CH_ZERO;
            sdf_pkg::KIND_SIGN:  char_next = neg_reg ? sdf_pkg::CH_MINUS : sdf_pkg::CH_PLUS;
            sdf_pkg::KIND_DIGIT: char_next = sdf_pkg::CH_ZERO + {4'd0, top_digit};
            default:             char_next = sdf_pkg::CH_SPACE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_char_reg  <= char_next;
            last_char_reg <= cmd.last;
        end
    end

    assign sts.top_zero = (top_digit == 4'd0);
    assign sts.has_sign = neg_reg || force_plus;
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last_char = last_char_reg;

endmodule

FILE: hw/rtl/sdf_ctrl.sv
// Controller: sequences conversion, leading-zero removal and the
// character phases (pad, sign, zeros, digits, trailing pad). Uses sdf_pkg.
module sdf_ctrl #(
    parameter int MAX_WIDTH = sdf_pkg::MAX_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [5:0]        field_width,
    input  logic              left_justify,
    input  logic              zero_pad,
    input  sdf_pkg::sdf_sts_t sts,
    output sdf_pkg::sdf_cmd_t cmd
);

    localparam int PW = $clog2(MAX_WIDTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_NORM,
        S_PRE,
        S_SIGN,
        S_ZPAD,
        S_DIG,
        S_POST
    } state_t;

    state_t                     state_reg, state_next;
    logic [sdf_pkg::STEP_W-1:0] cnt_reg, cnt_next;
    logic [sdf_pkg::ND_W-1:0]   nd_reg, nd_next;
    logic [PW-1:0]              pad_reg, pad_next;
    logic [PW-1:0]              width_sat;
    logic [PW:0]                len_x;
    logic [PW:0]                width_x;
    logic [PW-1:0]              pad_calc;
    logic                       mode_pre;
    logic                       mode_zero;
    logic                       post_pad;

    assign mode_pre  = !left_justify && !zero_pad;
    assign mode_zero = !left_justify && zero_pad;
    assign post_pad  = left_justify && (pad_reg != '0);

    always_comb
    begin
        if (int'(field_width) > MAX_WIDTH)
            width_sat = PW'(MAX_WIDTH);
        else
            width_sat = PW'(field_width);
        width_x  = (PW+1)'(width_sat);
        len_x    = (PW+1)'(nd_reg) + (PW+1)'(sts.has_sign);
        pad_calc = (width_x > len_x) ? PW'(width_x - len_x) : '0;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        nd_next    = nd_reg;
        pad_next   = pad_reg;
        cmd        = '0;
        cmd.kind   = sdf_pkg::KIND_SPACE;
        in_ready   = (state_reg == S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                cmd.dabble = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == sdf_pkg::STEP_W'(sdf_pkg::STEPS - 1))
                begin
                    nd_next    = sdf_pkg::ND_W'(sdf_pkg::ND_MAX);
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                // Drop leading zero digits, keeping at least one digit.
                if (sts.top_zero && nd_reg > sdf_pkg::ND_W'(1))
                begin
                    cmd.norm = 1'b1;
                    nd_next  = nd_reg - 1'b1;
                end
                else
                begin
                    pad_next = pad_calc;
                    if (pad_calc != '0 && mode_pre)
                        state_next = S_PRE;
                    else if (sts.has_sign)
                        state_next = S_SIGN;
                    else if (pad_calc != '0 && mode_zero)
                        state_next = S_ZPAD;
                    else
                        state_next = S_DIG;
                end
            end
            S_PRE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.kind = sdf_pkg::KIND_SPACE;
                    pad_next = pad_reg - 1'b1;
                    if (pad_reg == PW'(1))
                        state_next = sts.has_sign ? S_SIGN : S_DIG;
                end
            end
            S_SIGN:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = sdf_pkg::KIND_SIGN;
                    state_next = (pad_reg != '0 && mode_zero) ? S_ZPAD : S_DIG;
                end
            end
            S_ZPAD:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.kind = sdf_pkg::KIND_ZERO;
                    pad_next = pad_reg - 1'b1;
                    if (pad_reg == PW'(1))
                        state_next = S_DIG;
                end
            end
            S_DIG:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.kind = sdf_pkg::KIND_DIGIT;
                    cmd.last = (nd_reg == sdf_pkg::ND_W'(1)) && !post_pad;
                    nd_next  = nd_reg - 1'b1;
                    if (nd_reg == sdf_pkg::ND_W'(1))
                        state_next = post_pad ? S_POST : S_IDLE;
                end
            end
            S_POST:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.kind = sdf_pkg::KIND_SPACE;
                    cmd.last = (pad_reg == PW'(1));
                    pad_next = pad_reg - 1'b1;
                    if (pad_reg == PW'(1))
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            nd_reg    <= '0;
            pad_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            nd_reg    <= nd_next;
            pad_reg   <= pad_next;
        end
    end

    a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("character issued while the output register is occupied");

    a_digit_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIG) |-> (nd_reg != '0))
        else $error("digit phase entered with no digits left");

    a_pad_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(pad_reg) <= MAX_WIDTH))
        else $error("pad count exceeds the maximum field width");

    a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.last) |=> (state_reg == S_IDLE))
        else $error("final character issued but the sequence did not end");

endmodule

FILE: tb/sv/signed_decimal_formatter_test.sv
// Self-checking testbench for signed_decimal_formatter: predicts the %d text of
// every accepted argument and checks each character beat against it.
// Depends on sdf_pkg, sdf_arg_if, sdf_text_if and the formatter RTL.
`timescale 1ns / 1ps

module signed_decimal_formatter_test;

    localparam logic [2:0] LM_UNLISTED  = 3'd7;
    localparam int         CYCLE_LIMIT  = 1000000;
    localparam int         IDLE_GAP     = 110;
    localparam int         DRAIN_CYCLES = 200;
    localparam int         LONG_HOLD    = 500;
    localparam int         PHASES       = 12;
    localparam int         PHASE_ITEMS  = 24;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_beat_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                          cfg_we;
    logic [sdf_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [sdf_pkg::CFG_DATA_W-1:0] cfg_data;

    sdf_arg_if  arg ();
    sdf_text_if text ();

    signed_decimal_formatter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .arg       (arg.sink),
        .text      (text.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Format settings as currently programmed into the block.
    logic [5:0] fmt_width;
    logic       fmt_left;
    logic       fmt_zero_fill;
    logic       fmt_plus;
    logic [2:0] fmt_length;

    logic [63:0] pending_args[$];
    text_beat_t  expected_text[$];
    int          send_idle_pct;
    int          recv_idle_pct;
    int          mismatch_count;
    int          cycle_count = 0;
    int          hold_left;
    bit          hold_request;
    bit          hold_done;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Builds the full character sequence for one argument under the
    // current settings and queues it, the final character marked.
    function automatic void predict_text(input logic [63:0] raw);
        logic [63:0] v;
        logic [63:0] mag;
        logic [63:0] rem;
        logic        neg;
        logic        has_sign;
        logic [7:0]  sign_ch;
        logic [7:0]  digit_q[$];
        logic [7:0]  line[$];
        text_beat_t  beat;
        int          width;
        int          len;
        int          pad;
        case (fmt_length)
            sdf_pkg::LM_CHAR:  v = {{56{raw[7]}}, raw[7:0]};
            sdf_pkg::LM_SHORT: v = {{48{raw[15]}}, raw[15:0]};
            sdf_pkg::LM_LONG, sdf_pkg::LM_LLONG,
            sdf_pkg::LM_INTMAX, sdf_pkg::LM_SIZE: v = raw;
            default:  v = {{32{raw[31]}}, raw[31:0]};
        endcase
        neg = v[63];
        // The most negative value wraps to its own magnitude when unsigned.
        mag = neg ? (64'd0 - v) : v;
        do
        begin
            rem = mag % 64'd10;
            digit_q.push_front(sdf_pkg::CH_ZERO + rem[7:0]);
            mag = mag / 64'd10;
        end
        while (mag != 64'd0);

        has_sign = neg || fmt_plus;
        sign_ch  = neg ? sdf_pkg::CH_MINUS : sdf_pkg::CH_PLUS;
        width = (fmt_width > sdf_pkg::MAX_WIDTH_DEF) ? sdf_pkg::MAX_WIDTH_DEF
                                                      : int'(fmt_width);
        len   = digit_q.size() + (has_sign ? 1 : 0);
        pad   = (width > len) ? width - len : 0;

        if (fmt_left)
        begin
            if (has_sign)
                line.push_back(sign_ch);
            foreach (digit_q[i])
                line.push_back(digit_q[i]);
            repeat (pad)
                line.push_back(sdf_pkg::CH_SPACE);
        end
        else if (fmt_zero_fill)
        begin
            if (has_sign)
                line.push_back(sign_ch);
            repeat (pad)
                line.push_back(sdf_pkg::CH_ZERO);
            foreach (digit_q[i])
                line.push_back(digit_q[i]);
        end
        else
        begin
            repeat (pad)
                line.push_back(sdf_pkg::CH_SPACE);
            if (has_sign)
                line.push_back(sign_ch);
            foreach (digit_q[i])
                line.push_back(digit_q[i]);
        end

        foreach (line[i])
        begin
            beat.ch   = line[i];
            beat.last = (i == line.size() - 1);
            expected_text.push_back(beat);
        end
    endfunction

    // Arguments with a spread of digit counts, full random bits and extremes.
    function automatic logic [63:0] random_raw();
        logic [63:0] v;
        int          bits;
        v = {$urandom, $urandom};
        case ($urandom_range(7))
            0, 1: ;
            2:
            begin
                case ($urandom_range(5))
                    0: v = 64'd0;
                    1: v = '1;
                    2: v = 64'h7FFF_FFFF_FFFF_FFFF;
                    3: v = 64'h8000_0000_0000_0000;
                    4: v = {v[63:32], 32'h8000_0000};
                    default: v = 64'($urandom_range(9));
                endcase
            end
            default:
            begin
                bits = $urandom_range(64, 1);
                v = v >> (64 - bits);
                if ($urandom_range(1) == 1)
                    v = 64'd0 - v;
            end
        endcase
        return v;
    endfunction

    // Checked on the falling edge so that the driver's updates have settled.
    task automatic wait_idle();
        while (pending_args.size() != 0 || arg.valid || expected_text.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [sdf_pkg::CFG_IDX_W-1:0] index,
                             input logic [sdf_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
    endtask

    // Narrow registers get random upper bits, which the block must ignore.
    task automatic set_format(input logic [5:0] width, input bit left, input bit zero_fill,
                              input bit plus, input logic [2:0] length);
        logic [sdf_pkg::CFG_DATA_W-1:0] junk;
        wait_idle();
        repeat (IDLE_GAP) @(posedge clk);
        junk = sdf_pkg::CFG_DATA_W'($urandom);
        write_reg(sdf_pkg::REG_FIELD_WIDTH, width);
        write_reg(sdf_pkg::REG_LEFT_JUSTIFY, {junk[5:1], left});
        write_reg(sdf_pkg::REG_ZERO_PAD, {junk[4:0], zero_fill});
        write_reg(sdf_pkg::REG_FORCE_PLUS, {junk[5:2], junk[0], plus});
        write_reg(sdf_pkg::REG_LENGTH_MODE, {junk[2:0], length});
        @(posedge clk);
        cfg_we <= 1'b0;
        fmt_width     = width;
        fmt_left      = left;
        fmt_zero_fill = zero_fill;
        fmt_plus      = plus;
        fmt_length    = length;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arg.valid     <= 1'b0;
            arg.raw_value <= '0;
        end
        else
        begin
            if (arg.valid && arg.ready)
                predict_text(arg.raw_value);
            if (!arg.valid || arg.ready)
            begin
                if (pending_args.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    arg.valid     <= 1'b1;
                    arg.raw_value <= pending_args.pop_front();
                end
                else
                    arg.valid <= 1'b0;
            end
        end
    end

    // One long receiver stall, started while a number is being emitted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_request && !hold_done && text.valid)
        begin
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            text.ready <= 1'b0;
        else
        begin
            if (text.valid && text.ready)
            begin
                if (expected_text.size() == 0)
                begin
                    $error("unexpected beat: out_char %h last_char %b",
                           text.out_char, text.last_char);
                    mismatch_count++;
                end
                else
                begin
                    if (text.out_char !== expected_text[0].ch)
                    begin
                        $error("out_char: expected %h, actual %h",
                               expected_text[0].ch, text.out_char);
                        mismatch_count++;
                    end
                    if (text.last_char !== expected_text[0].last)
                    begin
                        $error("last_char: expected %b, actual %b",
                               expected_text[0].last, text.last_char);
                        mismatch_count++;
                    end
                    void'(expected_text.pop_front());
                end
            end
            text.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** signed_decimal_formatter: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int phase;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        mismatch_count = 0;
        hold_request   = 1'b0;
        send_idle_pct  = 33;
        recv_idle_pct  = 88;
        fmt_width      = '0;
        fmt_left       = 1'b0;
        fmt_zero_fill  = 1'b0;
        fmt_plus       = 1'b0;
        fmt_length     = sdf_pkg::LM_INT;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: zero, minus one, the int32 maximum, the int32 minimum with
        // junk above bit 31, and a value whose low word is zero.
        pending_args.push_back(64'd0);
        pending_args.push_back('1);
        pending_args.push_back(64'h0000_0000_7FFF_FFFF);
        pending_args.push_back(64'hDEAD_BEEF_8000_0000);
        pending_args.push_back(64'hFFFF_FFFF_0000_0000);

        // Width above the maximum saturates; zero fill follows the sign.
        set_format(6'd63, 1'b0, 1'b1, 1'b1, sdf_pkg::LM_LLONG);
        pending_args.push_back(64'd0);
        pending_args.push_back(64'h7FFF_FFFF_FFFF_FFFF);
        pending_args.push_back(64'h8000_0000_0000_0000);
        pending_args.push_back('1);
        pending_args.push_back(64'd12345);

        // Left justify wins over zero fill.
        set_format(6'd20, 1'b1, 1'b1, 1'b1, sdf_pkg::LM_CHAR);
        pending_args.push_back(64'hABCD_0000_0000_017F);
        pending_args.push_back(64'h0000_0000_0000_0080);
        pending_args.push_back(64'h0000_0000_0000_00FF);
        pending_args.push_back(64'h0000_0000_0000_0100);
        pending_args.push_back(64'h1234_5678_9ABC_DE55);

        set_format(6'd7, 1'b0, 1'b0, 1'b0, sdf_pkg::LM_SHORT);
        pending_args.push_back(64'h0000_0000_0000_7FFF);
        pending_args.push_back(64'h0000_0000_0000_8000);
        pending_args.push_back(64'h1234_5678_9ABC_FFFF);
        pending_args.push_back(64'h0000_0000_ABCD_0000);

        // The unlisted length mode narrows like int32.
        set_format(6'd1, 1'b0, 1'b1, 1'b0, LM_UNLISTED);
        pending_args.push_back(64'h0000_0001_8000_0000);
        pending_args.push_back(64'hFFFF_FFFF_7FFF_FFFF);

        set_format(6'd0, 1'b0, 1'b0, 1'b0, sdf_pkg::LM_LONG);
        pending_args.push_back(64'h8000_0000_0000_0000);
        set_format(6'd25, 1'b0, 1'b0, 1'b1, sdf_pkg::LM_INTMAX);
        pending_args.push_back(64'h7FFF_FFFF_FFFF_FFFF);
        set_format(6'd2, 1'b1, 1'b0, 1'b0, sdf_pkg::LM_SIZE);
        pending_args.push_back(64'hFFFF_FFFF_FFFF_FFF6);

        for (phase = 0; phase < PHASES; phase++)
        begin
            if (phase < 4)
            begin
                send_idle_pct = 33;
                recv_idle_pct = 88;
            end
            else if (phase < 8)
            begin
                send_idle_pct = 88;
                recv_idle_pct = 33;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            case (phase)
                0:  set_format(6'd0, 1'b0, 1'b0, 1'b0, sdf_pkg::LM_INT);
                6:  set_format(6'd63, 1'b1, 1'b1, 1'b1, LM_UNLISTED);
                11: set_format(6'd32, 1'b0, 1'b1, 1'b1, sdf_pkg::LM_LLONG);
                default:
                    set_format(($urandom_range(3) == 0) ? 6'($urandom_range(63))
                                                        : 6'($urandom_range(24)),
                               1'($urandom), 1'($urandom), 1'($urandom),
                               3'($urandom_range(7)));
            endcase

            // With no idling on either side, a long receiver stall lets the
            // block back up while arguments keep being offered.
            if (phase == 8)
                hold_request = 1'b1;

            repeat (PHASE_ITEMS)
                pending_args.push_back(random_raw());
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_text.size() == 0)
            $display("** signed_decimal_formatter: PASSED **");
        else
            $display("** signed_decimal_formatter: FAILED **");
        $finish;
    end

endmodule
